// ===== rtl/core/u8bmp_pkg.sv =====
// Shared types and constants for the UTF-8 to BMP stream decoder.
package u8bmp_pkg;

  localparam int unsigned LimitWidth = 16;
  localparam int unsigned CountWidth = 17;
  localparam logic [LimitWidth-1:0] LimitReset = 16'hFFFF;

  typedef enum logic [0:0] {
    CFG_BYTE_LIMIT  = 1'b0,
    CFG_POINT_LIMIT = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_STOPPED = 2'd0,
    PH_LEAD    = 2'd1,
    PH_CONT    = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    KIND_POINT   = 3'd0,
    KIND_END     = 3'd1,
    KIND_INVALID = 3'd2,
    KIND_BYTES   = 3'd3,
    KIND_FULL    = 3'd4
  } kind_t;

  typedef struct packed {
    phase_t                phase;
    logic [1:0]            pending;
    logic [15:0]           partial;
    logic [CountWidth-1:0] bytes_taken;
    logic [LimitWidth-1:0] points_done;
  } dec_state_t;

  typedef struct packed {
    logic                  emit;
    kind_t                 kind;
    logic [15:0]           code_point;
    logic [LimitWidth-1:0] point_count;
  } dec_result_t;

endpackage

// ===== rtl/core/u8bmp_step.sv =====
// Next-state and result logic for one UTF-8 byte.
module u8bmp_step
  import u8bmp_pkg::*;
(
  input  dec_state_t            cur,
  input  logic [7:0]            in_byte,
  input  logic                  begins_string,
  input  logic [LimitWidth-1:0] byte_limit,
  input  logic [LimitWidth-1:0] point_limit,
  output dec_state_t            nxt,
  output dec_result_t           res
);

  dec_state_t st;
  logic       finish;
  logic [1:0] pend_dec;

  always_comb begin
    st = cur;
    if (begins_string) begin
      st.phase       = PH_LEAD;
      st.pending     = 2'd0;
      st.partial     = 16'd0;
      st.bytes_taken = '0;
      st.points_done = '0;
    end

    nxt         = st;
    res         = '0;
    res.kind    = KIND_POINT;
    finish      = 1'b0;
    pend_dec    = st.pending - 2'd1;

    case (st.phase)
      PH_CONT: begin
        nxt.bytes_taken = st.bytes_taken + CountWidth'(1);
        nxt.partial     = {st.partial[9:0], in_byte[5:0]};
        nxt.pending     = pend_dec;
        finish          = (pend_dec == 2'd0);
      end
      PH_LEAD: begin
        if (st.points_done == point_limit) begin
          nxt.phase = PH_STOPPED;
          res.emit  = 1'b1;
          res.kind  = KIND_FULL;
        end else begin
          nxt.bytes_taken = st.bytes_taken + CountWidth'(1);
          if (!in_byte[7]) begin
            nxt.partial = {8'd0, in_byte};
            finish      = 1'b1;
          end else if (in_byte[7:6] == 2'b10 || in_byte[7:4] == 4'hF) begin
            nxt.phase = PH_STOPPED;
            res.emit  = 1'b1;
            res.kind  = KIND_INVALID;
          end else if (in_byte[7:5] == 3'b110) begin
            nxt.partial = {11'd0, in_byte[4:0]};
            nxt.pending = 2'd1;
            nxt.phase   = PH_CONT;
          end else begin
            nxt.partial = {12'd0, in_byte[3:0]};
            nxt.pending = 2'd2;
            nxt.phase   = PH_CONT;
          end
        end
      end
      default: begin
        nxt = st;
      end
    endcase

    if (finish) begin
      res.emit = 1'b1;
      if (nxt.bytes_taken > {1'b0, byte_limit}) begin
        nxt.phase = PH_STOPPED;
        res.kind  = KIND_BYTES;
      end else if (nxt.partial == 16'd0) begin
        nxt.phase       = PH_STOPPED;
        res.kind        = KIND_END;
        res.point_count = st.points_done;
      end else begin
        nxt.points_done = st.points_done + LimitWidth'(1);
        nxt.phase       = PH_LEAD;
        res.kind        = KIND_POINT;
        res.code_point  = nxt.partial;
      end
    end
  end

endmodule

// ===== rtl/core/utf8_to_bmp_stream_decoder.sv =====
// Top level of the UTF-8 to BMP stream decoder.
// Takes UTF-8 bytes and gives at most one result per byte, registered in the
// cycle after the byte is accepted; with the result side ready a byte is taken
// on every clock. The result register acts as the only buffer: a new byte is
// taken whenever that register is empty or being drained in the same cycle. Set
// in_tuser on the first byte of a string; after an end of string or any error,
// bytes are dropped without result until the next string start. Limits are
// written through the cfg_ port; the user must write them only while no string
// is in flight, as the block itself does not enforce this.
module utf8_to_bmp_stream_decoder
  import u8bmp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] in_byte
  input  logic                  in_tuser,   // [0] begins_string
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [15:0] code_point, [31:16] point_count
  output logic [2:0]            out_tuser,  // [2:0] kind
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [0:0]            cfg_index,
  input  logic [LimitWidth-1:0] cfg_data
);

  logic [LimitWidth-1:0] byte_limit_r;
  logic [LimitWidth-1:0] point_limit_r;
  dec_state_t            state_r;
  dec_state_t            state_nxt;
  dec_result_t           res;
  logic                  out_valid_r;
  kind_t                 kind_r;
  logic [15:0]           code_point_r;
  logic [LimitWidth-1:0] point_count_r;
  logic                  in_fire;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {point_count_r, code_point_r};
  assign out_tuser  = kind_r;

  u8bmp_step u_step (
    .cur           (state_r),
    .in_byte       (in_tdata),
    .begins_string (in_tuser),
    .byte_limit    (byte_limit_r),
    .point_limit   (point_limit_r),
    .nxt           (state_nxt),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_limit_r  <= LimitReset;
      point_limit_r <= LimitReset;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_BYTE_LIMIT:  byte_limit_r  <= cfg_data;
        CFG_POINT_LIMIT: point_limit_r <= cfg_data;
        default:         byte_limit_r  <= byte_limit_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase       <= PH_STOPPED;
      state_r.pending     <= 2'd0;
      state_r.partial     <= 16'd0;
      state_r.bytes_taken <= '0;
      state_r.points_done <= '0;
      out_valid_r         <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= res.emit;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res.emit) begin
      kind_r        <= res.kind;
      code_point_r  <= res.code_point;
      point_count_r <= res.point_count;
    end
  end

endmodule

// ===== verif/u8bmp_scoreboard_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard class that predicts decoder results from accepted bytes and checks them.
package u8bmp_scoreboard_pkg;
  import u8bmp_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [15:0] code_point;
    logic [15:0] point_count;
  } decoded_t;

  class utf8_scoreboard;
    logic [15:0] byte_limit;
    logic [15:0] point_limit;
    phase_t      phase;
    logic [1:0]  pending;
    logic [15:0] partial;
    logic [16:0] bytes_taken;
    logic [15:0] points_done;
    decoded_t    decoded_q[$];
    int          mismatches;

    function new();
      byte_limit  = LimitReset;
      point_limit = LimitReset;
      phase       = PH_STOPPED;
      pending     = 2'd0;
      partial     = 16'h0;
      bytes_taken = 17'h0;
      points_done = 16'h0;
      mismatches  = 0;
    endfunction

    function void write_limit(cfg_index_t idx, logic [15:0] value);
      if (idx == CFG_BYTE_LIMIT) begin
        byte_limit = value;
      end else begin
        point_limit = value;
      end
    endfunction

    function void queue_result(kind_t kind, logic [15:0] cp, logic [15:0] count);
      decoded_t d;
      d.kind        = kind;
      d.code_point  = cp;
      d.point_count = count;
      decoded_q.push_back(d);
    endfunction

    function void complete_point();
      if (bytes_taken > {1'b0, byte_limit}) begin
        phase = PH_STOPPED;
        queue_result(KIND_BYTES, 16'h0, 16'h0);
      end else if (partial == 16'h0) begin
        phase = PH_STOPPED;
        queue_result(KIND_END, 16'h0, points_done);
      end else begin
        points_done = points_done + 16'd1;
        phase       = PH_LEAD;
        queue_result(KIND_POINT, partial, 16'h0);
      end
    endfunction

    function void note_byte(logic [7:0] b, logic starts);
      if (starts) begin
        phase       = PH_LEAD;
        pending     = 2'd0;
        partial     = 16'h0;
        bytes_taken = 17'h0;
        points_done = 16'h0;
      end
      if (phase == PH_CONT) begin
        bytes_taken = bytes_taken + 17'd1;
        partial     = {partial[9:0], b[5:0]};
        pending     = pending - 2'd1;
        if (pending == 2'd0) complete_point();
      end else if (phase == PH_LEAD) begin
        if (points_done == point_limit) begin
          phase = PH_STOPPED;
          queue_result(KIND_FULL, 16'h0, 16'h0);
        end else begin
          bytes_taken = bytes_taken + 17'd1;
          if (!b[7]) begin
            partial = {8'h00, b};
            complete_point();
          end else if (b[7:6] == 2'b10 || b[7:4] == 4'hF) begin
            phase = PH_STOPPED;
            queue_result(KIND_INVALID, 16'h0, 16'h0);
          end else if (b[7:5] == 3'b110) begin
            partial = {11'h0, b[4:0]};
            pending = 2'd1;
            phase   = PH_CONT;
          end else begin
            partial = {12'h0, b[3:0]};
            pending = 2'd2;
            phase   = PH_CONT;
          end
        end
      end
    endfunction

    function void check_result(logic [2:0] kind, logic [15:0] cp, logic [15:0] count);
      decoded_t d;
      if (decoded_q.size() == 0) begin
        mismatches++;
        $display("%0t: expected no result, actual kind %0d code_point %h point_count %0d",
                 $time, kind, cp, count);
        return;
      end
      d = decoded_q.pop_front();
      if (kind !== d.kind) begin
        mismatches++;
        $display("%0t: kind expected %0d actual %0d", $time, d.kind, kind);
      end
      if (cp !== d.code_point) begin
        mismatches++;
        $display("%0t: code_point expected %h actual %h", $time, d.code_point, cp);
      end
      if (count !== d.point_count) begin
        mismatches++;
        $display("%0t: point_count expected %0d actual %0d", $time, d.point_count, count);
      end
    endfunction

    function int outstanding();
      return decoded_q.size();
    endfunction
  endclass

endpackage

// ===== verif/utf8_to_bmp_stream_decoder_tb.sv =====
`timescale 1ns / 100ps
// Testbench for the UTF-8 to BMP stream decoder: directed strings, then random phases.
module utf8_to_bmp_stream_decoder_tb;
  import u8bmp_pkg::*;
  import u8bmp_scoreboard_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;

  utf8_scoreboard sb = new();
  bit idle_on;
  bit hold_req;
  bit new_string;
  int sent;

  utf8_to_bmp_stream_decoder u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        sb.check_result(out_tuser, out_tdata[15:0], out_tdata[31:16]);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 60;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic starts);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= starts;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b, starts);
    sent++;
  endtask

  task automatic put(input logic [7:0] b);
    send_byte(b, new_string);
    new_string = 1'b0;
  endtask

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  task automatic send_random_string();
    int nchar;
    int sel;
    new_string = 1'b1;
    nchar = $urandom_range(0, 10);
    for (int i = 0; i < nchar; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        put(($urandom_range(0, 1) == 1) ? {2'b10, 6'($urandom_range(0, 63))}
                                        : {4'hF, 4'($urandom_range(0, 15))});
      end else if (sel < 45) begin
        put(8'($urandom_range(1, 127)));
      end else if (sel < 70) begin
        put({3'b110, 5'($urandom_range(0, 31))});
        put(cont_byte());
      end else begin
        put({4'hE, 4'($urandom_range(0, 15))});
        // truncate: the next string start lands mid-sequence
        if ($urandom_range(0, 19) == 0) return;
        put(cont_byte());
        put(cont_byte());
      end
    end
    sel = $urandom_range(0, 99);
    if (sel < 85) begin
      put(8'h00);
    end else if (sel < 92) begin
      put(8'hC0);
      put(8'h80);
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 3))
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_limits(input logic [15:0] byte_v, input logic [15:0] point_v);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_BYTE_LIMIT;
    cfg_data  <= byte_v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_limit(CFG_BYTE_LIMIT, byte_v);
    cfg_index <= CFG_POINT_LIMIT;
    cfg_data  <= point_v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_limit(CFG_POINT_LIMIT, point_v);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] byte_v, input logic [15:0] point_v,
                           input int items, input bit with_hold);
    int target;
    // stop any string in flight before touching the limits
    send_byte(8'hFF, 1'b1);
    wait_idle();
    set_limits(byte_v, point_v);
    if (with_hold) hold_req = 1'b1;
    target = sent + items;
    while (sent < target) begin
      if ($urandom_range(0, 9) < 8) send_random_string();
      else send_noise();
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    in_tuser  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_BYTE_LIMIT;
    cfg_data  <= 16'h0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    new_string = 1'b0;
    sent       = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h7F, 1'b1);
    send_byte(8'hC2, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hE0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hE1, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF0, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hE2, 1'b1);
    send_byte(8'h82, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'h00, 1'b0);

    run_phase(16'h0000, 16'hFFFF, 30, 1'b0);
    run_phase(16'hFFFF, 16'h0000, 30, 1'b0);
    run_phase(16'd12, 16'd4, 100, 1'b1);
    run_phase(16'($urandom_range(0, 30)), 16'($urandom_range(0, 8)), 100, 1'b0);
    run_phase(16'($urandom_range(5, 40)), 16'($urandom_range(2, 12)), 100, 1'b1);
    idle_on = 1'b0;
    run_phase(16'hFFFF, 16'hFFFF, 100, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
